### rtl/lrl_pkg.sv
// ----------------------------------------------------------------------------
// lrl_pkg
// shared codes for the lru recency list: operation and status encodings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lrl_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_UNLINK = 2'd1,
    OP_MOVE   = 2'd2
  } opcode_t;

  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

endpackage

`default_nettype wire

### rtl/lrl_if.sv
// ----------------------------------------------------------------------------
// lrl_if
// valid/ready channels of the lru recency list: operation in, list state out
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lru_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [3:0] entry;

  modport source (output valid, output opcode, output entry, input ready);
  modport sink   (input valid, input opcode, input entry, output ready);
endinterface

interface lru_out_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic       empty_res;
  logic [3:0] head_entry;
  logic [3:0] tail_entry;

  modport source (output valid, output status, output empty_res, output head_entry,
                  output tail_entry, input ready);
  modport sink   (input valid, input status, input empty_res, input head_entry,
                  input tail_entry, output ready);
endinterface

`default_nettype wire

### rtl/lru_recency_list.sv
// ----------------------------------------------------------------------------
// lru_recency_list
// recency order over cache entries as a doubly linked list in two link rams
// ----------------------------------------------------------------------------
// One operation at a time: insert at head, unlink, or move to head, each
// answered by one transaction carrying status, empty flag, head and tail.
// Previous and next links live in two rams with registered reads, head, tail,
// empty and per-entry linked flags in flops. An operation that does not fit
// the entry's linked state, an undefined opcode or an entry at or beyond
// ENTRIES is ignored with status 1. Before the next operation is accepted,
// an ignored one or a move of the head goes to DONE; insert steps through
// PUSH1, PUSH2 and DONE, unlink through DET and DONE, move through DET,
// PUSH1, PUSH2 and DONE. The sequencer makes one write per link ram per
// cycle and the named entry's link read is registered. The input is taken
// while a result waits on the output; the sequencer then holds its result
// until the output register frees. Link rams need no clearing after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lru_recency_list #(
  parameter int ENTRIES = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  lru_in_if.sink     in_ch,
  lru_out_if.source  out_ch
);

  import lrl_pkg::*;

  localparam int IW  = $clog2(ENTRIES);
  localparam int LW  = $clog2(ENTRIES + 1);
  localparam int NL  = (ENTRIES < 16) ? ENTRIES : 16;
  localparam int LIW = $clog2(NL);
  localparam logic [LW-1:0] NO_LINK = LW'(ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DET,
    S_PUSH1,
    S_PUSH2,
    S_DONE
  } state_t;

  state_t        state_r;
  logic          move_r;
  logic          status_r;
  logic [IW-1:0] e_r;
  logic [IW-1:0] head_r;
  logic [IW-1:0] tail_r;
  logic          empty_r;
  logic [NL-1:0] linked_r;

  logic          out_valid_r;
  logic          out_status_r;
  logic          out_empty_r;
  logic [3:0]    out_head_r;
  logic [3:0]    out_tail_r;

  logic          prev_we;
  logic [IW-1:0] prev_waddr;
  logic [LW-1:0] prev_wdata;
  logic [LW-1:0] prev_q;
  logic          next_we;
  logic [IW-1:0] next_waddr;
  logic [LW-1:0] next_wdata;
  logic [LW-1:0] next_q;
  logic [IW-1:0] raddr;

  logic          in_rng;
  logic          in_lk;
  logic [IW-1:0] in_e;
  logic          p_ok;
  logic          n_ok;
  logic          out_free;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_rng      = (32'(in_ch.entry) < ENTRIES);
  assign in_e        = IW'(in_ch.entry);
  assign in_lk       = linked_r[in_ch.entry[LIW-1:0]];
  assign p_ok        = (prev_q < NO_LINK);
  assign n_ok        = (next_q < NO_LINK);
  assign raddr       = (state_r == S_IDLE) ? in_e : e_r;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.status     = out_status_r;
  assign out_ch.empty_res  = out_empty_r;
  assign out_ch.head_entry = out_head_r;
  assign out_ch.tail_entry = out_tail_r;

  // link ram write ports
  always_comb begin
    prev_we    = 1'b0;
    prev_waddr = e_r;
    prev_wdata = NO_LINK;
    next_we    = 1'b0;
    next_waddr = e_r;
    next_wdata = NO_LINK;
    unique case (state_r)
      S_DET: begin
        next_we    = p_ok;
        next_waddr = prev_q[IW-1:0];
        next_wdata = next_q;
        prev_we    = n_ok;
        prev_waddr = next_q[IW-1:0];
        prev_wdata = prev_q;
      end
      S_PUSH1: begin
        prev_we    = !empty_r;
        prev_waddr = head_r;
        prev_wdata = LW'(e_r);
        next_we    = 1'b1;
        next_waddr = e_r;
        next_wdata = empty_r ? NO_LINK : LW'(head_r);
      end
      S_PUSH2: begin
        prev_we    = 1'b1;
        prev_waddr = e_r;
        prev_wdata = NO_LINK;
      end
      default: begin
        prev_we = 1'b0;
        next_we = 1'b0;
      end
    endcase
  end

  lrl_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_prev_ram (
    .clk   (clk),
    .we    (prev_we),
    .waddr (prev_waddr),
    .wdata (prev_wdata),
    .raddr (raddr),
    .rdata (prev_q)
  );

  lrl_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_next_ram (
    .clk   (clk),
    .we    (next_we),
    .waddr (next_waddr),
    .wdata (next_wdata),
    .raddr (raddr),
    .rdata (next_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      linked_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            e_r      <= in_e;
            status_r <= STATUS_IGNORED;
            move_r   <= 1'b0;
            state_r  <= S_DONE;
            unique case (opcode_t'(in_ch.opcode))
              OP_INSERT: begin
                if (in_rng && !in_lk) begin
                  status_r <= STATUS_DONE;
                  state_r  <= S_PUSH1;
                end
              end
              OP_UNLINK: begin
                if (in_rng && in_lk) begin
                  status_r <= STATUS_DONE;
                  state_r  <= S_DET;
                end
              end
              OP_MOVE: begin
                if (in_rng && in_lk) begin
                  status_r <= STATUS_DONE;
                  move_r   <= 1'b1;
                  if (!(head_r == in_e && !empty_r)) begin
                    state_r <= S_DET;
                  end
                end
              end
              default: begin
                status_r <= STATUS_IGNORED;
              end
            endcase
          end
        end
        S_DET: begin
          if (!p_ok) begin
            head_r <= n_ok ? next_q[IW-1:0] : '0;
          end
          if (!n_ok) begin
            tail_r <= p_ok ? prev_q[IW-1:0] : '0;
          end
          if (!p_ok && !n_ok) begin
            empty_r <= 1'b1;
          end
          if (move_r) begin
            state_r <= S_PUSH1;
          end else begin
            linked_r[e_r[LIW-1:0]] <= 1'b0;
            state_r                <= S_DONE;
          end
        end
        S_PUSH1: begin
          if (empty_r) begin
            tail_r <= e_r;
          end
          head_r                 <= e_r;
          empty_r                <= 1'b0;
          linked_r[e_r[LIW-1:0]] <= 1'b1;
          state_r                <= S_PUSH2;
        end
        S_PUSH2: begin
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_status_r <= status_r;
            out_empty_r  <= empty_r;
            out_head_r   <= empty_r ? 4'd0 : 4'(head_r);
            out_tail_r   <= empty_r ? 4'd0 : 4'(tail_r);
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/lrl_ram.sv
// ----------------------------------------------------------------------------
// lrl_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### rtl/lrl_checker.sv
// ----------------------------------------------------------------------------
// lrl_checker
// port-level checks on the lru recency list result channel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lrl_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_status,
  input wire logic       out_empty,
  input wire logic [3:0] out_head,
  input wire logic [3:0] out_tail
);

  // no result without a reset-free cycle behind it
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // an empty list reports head and tail as zero
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_empty |-> (out_head == 4'd0) && (out_tail == 4'd0))
    else $error("empty list with nonzero head or tail");

  // one operation in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken again right after a transaction");

  // a stalled result holds its transaction
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) && $stable(out_empty)
      && $stable(out_head) && $stable(out_tail))
    else $error("stalled result changed");

endmodule

bind lru_recency_list lrl_checker u_lrl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_status(out_ch.status),
  .out_empty (out_ch.empty_res),
  .out_head  (out_ch.head_entry),
  .out_tail  (out_ch.tail_entry)
);

`default_nettype wire

### dv/lru_recency_list_tb.sv
// ----------------------------------------------------------------------------
// lru_recency_list_tb
// self-checking testbench for the lru recency list
// ----------------------------------------------------------------------------
// Drives insert, unlink and move operations over a valid/ready channel and
// predicts the status, empty flag, head and tail of every result from a
// private copy of the linked list. Directed sequences cover misuse, head and
// tail updates and emptying. Random traffic alternates between filling and
// draining the list. Both channels stall at random, with one quiet stretch
// and one pause until all results are back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lru_recency_list_tb;
  import lrl_pkg::*;

  localparam int          ENTRIES     = 16;
  localparam logic [4:0]  NO_LINK     = 5'd16;
  localparam logic [1:0]  OP_UNDEF    = 2'd3;
  localparam int          IDLE_PCT    = 29;
  localparam int          STALL_LIMIT = 5000;
  localparam int          RANDOM_OPS  = 590;

  typedef struct packed {
    logic       status;
    logic       empty_res;
    logic [3:0] head_entry;
    logic [3:0] tail_entry;
  } list_view_t;

  logic clk;
  logic rst_n;
  logic quiet;
  int   mismatch_count;
  int   idle_cycles;

  // predicted list
  logic [4:0] prev_q [ENTRIES];
  logic [4:0] next_q [ENTRIES];
  logic       linked_q [ENTRIES];
  logic [3:0] head_q;
  logic [3:0] tail_q;
  logic       empty_q;

  list_view_t pending_views [$];

  lru_in_if  in_ch ();
  lru_out_if out_ch ();

  lru_recency_list #(.ENTRIES(ENTRIES)) u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic void link_at_head(input logic [3:0] e);
    prev_q[e] = NO_LINK;
    if (empty_q) begin
      next_q[e] = NO_LINK;
      tail_q    = e;
    end else begin
      next_q[e]      = {1'b0, head_q};
      prev_q[head_q] = {1'b0, e};
    end
    head_q      = e;
    empty_q     = 1'b0;
    linked_q[e] = 1'b1;
  endfunction

  function automatic void unlink_entry(input logic [3:0] e);
    logic [4:0] p;
    logic [4:0] n;
    p = prev_q[e];
    n = next_q[e];
    if (p != NO_LINK) next_q[p[3:0]] = n;
    else head_q = (n != NO_LINK) ? n[3:0] : 4'd0;
    if (n != NO_LINK) prev_q[n[3:0]] = p;
    else tail_q = (p != NO_LINK) ? p[3:0] : 4'd0;
    if (p == NO_LINK && n == NO_LINK) begin
      empty_q = 1'b1;
      head_q  = 4'd0;
      tail_q  = 4'd0;
    end
    prev_q[e]   = NO_LINK;
    next_q[e]   = NO_LINK;
    linked_q[e] = 1'b0;
  endfunction

  function automatic list_view_t predict_view(input logic [1:0] op, input logic [3:0] e);
    list_view_t v;
    v.status = STATUS_IGNORED;
    case (op)
      OP_INSERT: begin
        if (!linked_q[e]) begin
          link_at_head(e);
          v.status = STATUS_DONE;
        end
      end
      OP_UNLINK: begin
        if (linked_q[e]) begin
          unlink_entry(e);
          v.status = STATUS_DONE;
        end
      end
      OP_MOVE: begin
        if (linked_q[e]) begin
          if (!(head_q == e && !empty_q)) begin
            unlink_entry(e);
            link_at_head(e);
          end
          v.status = STATUS_DONE;
        end
      end
      default: ;
    endcase
    v.empty_res  = empty_q;
    v.head_entry = empty_q ? 4'd0 : head_q;
    v.tail_entry = empty_q ? 4'd0 : tail_q;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // predict on accepted operations, check accepted results
  always @(posedge clk) begin : scoreboard
    list_view_t got;
    list_view_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        pending_views.push_back(predict_view(in_ch.opcode, in_ch.entry));
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.empty_res, out_ch.head_entry, out_ch.tail_entry};
        if (pending_views.size() == 0) begin
          report_mismatch("result transaction with no operation pending");
        end else begin
          want = pending_views.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("status got %0b expected %0b", got.status, want.status));
          if (got.empty_res !== want.empty_res)
            report_mismatch($sformatf("empty_res got %0b expected %0b",
                                      got.empty_res, want.empty_res));
          if (got.head_entry !== want.head_entry)
            report_mismatch($sformatf("head_entry got %0d expected %0d",
                                      got.head_entry, want.head_entry));
          if (got.tail_entry !== want.tail_entry)
            report_mismatch($sformatf("tail_entry got %0d expected %0d",
                                      got.tail_entry, want.tail_entry));
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("lru_recency_list verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // called and returns at a falling edge
  task automatic send_op(input logic [1:0] op, input logic [3:0] e);
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.opcode <= op;
    in_ch.entry  <= e;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic wait_results_drained();
    in_ch.valid <= 1'b0;
    while (pending_views.size() != 0) @(negedge clk);
  endtask

  function automatic void pick_op(input int ins_w, input int unl_w,
                                  output logic [1:0] op, output logic [3:0] e);
    int         roll;
    logic       want_linked;
    logic [3:0] cands [$];
    if ($urandom_range(99) < 20) begin
      op = 2'($urandom_range(3));
      e  = 4'($urandom_range(ENTRIES - 1));
      return;
    end
    roll = $urandom_range(99);
    if (roll < ins_w) op = OP_INSERT;
    else if (roll < ins_w + unl_w) op = OP_UNLINK;
    else op = OP_MOVE;
    want_linked = (op != OP_INSERT);
    for (int i = 0; i < ENTRIES; i++)
      if (linked_q[i] == want_linked) cands.push_back(4'(i));
    if (cands.size() == 0) begin
      op = want_linked ? OP_INSERT : OP_MOVE;
      for (int i = 0; i < ENTRIES; i++) cands.push_back(4'(i));
    end
    e = cands[$urandom_range(cands.size() - 1)];
  endfunction

  task automatic test_ignored_ops();
    send_op(OP_UNLINK, 4'd0);
    send_op(OP_MOVE, 4'd15);
    send_op(OP_UNDEF, 4'd0);
  endtask

  task automatic test_head_tail_updates();
    send_op(OP_INSERT, 4'd0);
    send_op(OP_INSERT, 4'd15);
    send_op(OP_INSERT, 4'd5);
    send_op(OP_INSERT, 4'd0);
    send_op(OP_MOVE, 4'd5);
    send_op(OP_MOVE, 4'd0);
    send_op(OP_MOVE, 4'd5);
    send_op(OP_UNDEF, 4'd15);
    send_op(OP_INSERT, 4'd10);
    send_op(OP_UNLINK, 4'd10);
    send_op(OP_UNLINK, 4'd15);
    send_op(OP_UNLINK, 4'd5);
    send_op(OP_MOVE, 4'd0);
    send_op(OP_UNLINK, 4'd0);
    send_op(OP_UNLINK, 4'd0);
  endtask

  task automatic test_random_traffic();
    logic [1:0] op;
    logic [3:0] e;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      quiet = (n >= 200 && n < 300);
      if (n == 300) wait_results_drained();
      // alternate fill and drain phases
      if ((n / 100) % 2 == 0) pick_op(50, 15, op, e);
      else pick_op(15, 50, op, e);
      send_op(op, e);
    end
    quiet = 1'b0;
  endtask

  initial begin
    rst_n          = 1'b0;
    quiet          = 1'b0;
    mismatch_count = 0;
    idle_cycles    = 0;
    in_ch.valid    = 1'b0;
    in_ch.opcode   = OP_INSERT;
    in_ch.entry    = 4'd0;
    out_ch.ready   = 1'b0;
    for (int i = 0; i < ENTRIES; i++) linked_q[i] = 1'b0;
    head_q  = 4'd0;
    tail_q  = 4'd0;
    empty_q = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_ignored_ops();
    test_head_tail_updates();
    test_random_traffic();

    wait_results_drained();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("lru_recency_list verification clean");
    end else begin
      $display("lru_recency_list verification failed");
    end
    $finish;
  end

endmodule

### files.f
rtl/lrl_pkg.sv
rtl/lrl_if.sv
rtl/lrl_ram.sv
rtl/lru_recency_list.sv
rtl/lrl_checker.sv
dv/lru_recency_list_tb.sv
